[hdl/pidc_pkg.sv]
// Package for the PID step unit: field widths, fixed-point constants and the
// request/response structs between the sequencer and its arithmetic units.
// No dependencies.
package pidc_pkg;

	localparam int DATA_W    = 32;          // Q16.16 words
	localparam int ERR_W     = 33;          // error, Q17.16
	localparam int DIFF_W    = 34;          // change in error
	localparam int SUM_W     = 48;          // integral, Q32.16
	localparam int FRAC_W    = 16;
	localparam int CFG_IDX_W = 2;

	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 32;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam int DIV_NUM_W = DIFF_W + FRAC_W;   // quotient width as well
	localparam int DIV_DEN_W = DATA_W;
	localparam int DIV_STEPS = DIV_NUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	localparam int XMAG_W = DIV_NUM_W;            // widest term operand
	localparam int ACC_W  = XMAG_W + MUL_B_W;     // full gain * operand product
	localparam int TMAG_W = ACC_W - FRAC_W;
	localparam int TERM_W = 64;

	localparam logic [TMAG_W-1:0] TERM_LIM = TMAG_W'(1) << 60;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN  = 2'd0,
		REG_INTEG_GAIN = 2'd1,
		REG_DERIV_GAIN = 2'd2,
		REG_TARGET     = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [DIV_NUM_W-1:0] quo;
	} div_rsp_t;

endpackage

[hdl/pidc_mul.sv]
// Shared unsigned multiplier of the PID step unit, product registered.
// Depends on pidc_pkg.
module pidc_mul (
	input  logic                       clk,
	input  pidc_pkg::mul_req_t         req,
	output logic [pidc_pkg::MUL_P_W-1:0] prod
);
	import pidc_pkg::*;

	logic [MUL_P_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= MUL_P_W'(req.a) * MUL_P_W'(req.b);
	end

	assign prod = prod_q;

endmodule

[hdl/pidc_div.sv]
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on pidc_pkg.
module pidc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  pidc_pkg::div_req_t req,
	output pidc_pkg::div_rsp_t rsp
);
	import pidc_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_NUM_W-1:0] num_q;   // dividend shifts out, quotient shifts in

	logic [DIV_DEN_W:0]   rem_sh;
	logic [DIV_DEN_W:0]   rem_sub;
	logic                 fits;

	assign rem_sh  = {rem_q, num_q[DIV_NUM_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign fits    = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.den;
			num_q <= req.num;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
			num_q <= {num_q[DIV_NUM_W-2:0], fits};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = num_q;

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && done_q))
		else $error("divider busy and done together");

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < den_q)
		else $error("partial remainder not below divisor");

	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !req.start && cnt_q == DIV_CNT_W'(1)) |=> done_q)
		else $error("divider did not finish after its last step");

endmodule

[hdl/pid_controller_step_unit.sv]
// PID step unit top level: configuration registers, loop state, sequencer
// around the shared multiplier and the divider, and the output register.
// Depends on pidc_pkg, pidc_mul and pidc_div.
//
//   channel  | direction | handshake                      | words
//   ---------+-----------+--------------------------------+---------------------------
//   s_axis   | in        | s_axis_tvalid / s_axis_tready  | measured, step_time
//   m_axis   | out       | m_axis_tvalid / m_axis_tready  | drive_value; clipped, bad
//   cfg      | in        | cfg_valid / cfg_ready          | register index, data
//
// A word with a non-zero step_time waits for the 50-step radix-2 divider of the
// derivative before its D term; the P and I terms run on the shared multiplier in
// its shadow. A zero step_time word goes from idle straight to the output state.
// Input is taken only while the sequencer is idle; a result waiting on m_axis
// holds only the next finished result.
// Reset clears gains, setpoint, integral, last error and last drive to zero.
// Configuration writes are always taken (cfg_ready is tied high).
module pid_controller_step_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// input words
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [63:0]                        s_axis_tdata,  // [31:0] measured, [63:32] step_time
	// result words
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [pidc_pkg::DATA_W-1:0]        m_axis_tdata,  // [31:0] drive_value
	output logic [1:0]                         m_axis_tuser,  // [0] clipped, [1] bad_interval
	// configuration writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pidc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pidc_pkg::DATA_W-1:0]        cfg_data
);
	import pidc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INT,       // issue |err| * dt, start the divider
		S_INT_ACC,   // fold the increment into the integral
		S_TSET,      // pick operands of the current term
		S_TLO,       // gain * low operand chunk
		S_THI,       // gain * high operand chunk
		S_TACC,      // add the shifted high partial product
		S_TEND,      // clamp and add the term to the total
		S_FIN,       // saturate the total, update loop state
		S_OUT        // hand the result to the output register
	} state_t;

	typedef enum logic [1:0] {
		TERM_P,
		TERM_I,
		TERM_D
	} term_t;

	state_t state_q;
	term_t  term_q;

	// configuration
	logic [DATA_W-1:0] kp_q, ki_q, kd_q, sp_q;

	// loop state
	logic [SUM_W-1:0]  esum_q;
	logic [ERR_W-1:0]  lerr_q;
	logic [DATA_W-1:0] ldrv_q;

	// per-word working registers
	logic [ERR_W-1:0]   err_q;
	logic [DATA_W-1:0]  dt_q;
	logic               dneg_q;
	logic               sat_q;
	logic [XMAG_W-1:0]  xmag_q;
	logic [MUL_B_W-1:0] gmag_q;
	logic               neg_q;
	logic [ACC_W-1:0]   acc_q;
	logic [TERM_W-1:0]  total_q;
	logic [DATA_W-1:0]  res_drive_q;
	logic               res_clip_q;
	logic               res_bad_q;

	// output register
	logic               out_valid_q;
	logic [DATA_W-1:0]  out_drive_q;
	logic               out_clip_q;
	logic               out_bad_q;

	mul_req_t           mul_req;
	logic [MUL_P_W-1:0] mul_p;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	function automatic logic [DATA_W-1:0] abs32(input logic [DATA_W-1:0] v);
		return v[DATA_W-1] ? (~v + 1'b1) : v;
	endfunction

	// input word fields
	logic [DATA_W-1:0] in_meas;
	logic [DATA_W-1:0] in_dt;
	assign in_meas = s_axis_tdata[31:0];
	assign in_dt   = s_axis_tdata[63:32];

	logic [ERR_W-1:0] err_in;
	assign err_in = {sp_q[DATA_W-1], sp_q} - {in_meas[DATA_W-1], in_meas};

	logic [ERR_W-1:0]  err_mag;
	logic [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0] diff_mag;
	logic [SUM_W-1:0]  esum_mag;
	assign err_mag  = err_q[ERR_W-1] ? (~err_q + 1'b1) : err_q;
	assign diff     = {err_q[ERR_W-1], err_q} - {lerr_q[ERR_W-1], lerr_q};
	assign diff_mag = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
	assign esum_mag = esum_q[SUM_W-1] ? (~esum_q + 1'b1) : esum_q;

	// integral increment: floor for positive error, ceiling of magnitude for negative
	logic [MUL_P_W:0]         inc_rnd;
	logic [MUL_P_W-FRAC_W:0]  inc_mag;
	logic [SUM_W+2:0]         sum_nx;
	logic                     sum_hi, sum_lo;
	logic [SUM_W-1:0]         sum_sat;
	assign inc_rnd = {1'b0, mul_p} + (err_q[ERR_W-1] ? (MUL_P_W+1)'(16'hFFFF) : '0);
	assign inc_mag = inc_rnd[MUL_P_W:FRAC_W];
	assign sum_nx  = err_q[ERR_W-1]
		? ({{3{esum_q[SUM_W-1]}}, esum_q} - (SUM_W+3)'(inc_mag))
		: ({{3{esum_q[SUM_W-1]}}, esum_q} + (SUM_W+3)'(inc_mag));
	assign sum_hi  = !sum_nx[SUM_W+2] && (|sum_nx[SUM_W+1:SUM_W-1]);
	assign sum_lo  = sum_nx[SUM_W+2] && !(&sum_nx[SUM_W+1:SUM_W-1]);
	always_comb begin
		if (sum_hi)
			sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
		else if (sum_lo)
			sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
		else
			sum_sat = sum_nx[SUM_W-1:0];
	end

	// term round-off is already in acc_q; clamp the magnitude at 2^60
	logic [TMAG_W-1:0] tmag;
	logic              tclip;
	logic [TERM_W-1:0] tval;
	assign tclip = acc_q[ACC_W-1:FRAC_W] > TERM_LIM;
	assign tmag  = tclip ? TERM_LIM : acc_q[ACC_W-1:FRAC_W];
	assign tval  = neg_q ? (~tmag[TERM_W-1:0] + 1'b1) : tmag[TERM_W-1:0];

	// final output saturation
	logic              tot_hi, tot_lo;
	logic [DATA_W-1:0] tot_sat;
	assign tot_hi = !total_q[TERM_W-1] && (|total_q[TERM_W-2:DATA_W-1]);
	assign tot_lo = total_q[TERM_W-1] && !(&total_q[TERM_W-2:DATA_W-1]);
	always_comb begin
		if (tot_hi)
			tot_sat = {1'b0, {(DATA_W-1){1'b1}}};
		else if (tot_lo)
			tot_sat = {1'b1, {(DATA_W-1){1'b0}}};
		else
			tot_sat = total_q[DATA_W-1:0];
	end

	// shared multiplier operands
	always_comb begin
		case (state_q)
			S_TLO: begin
				mul_req.a = {1'b0, xmag_q[31:0]};
				mul_req.b = gmag_q;
			end
			S_THI: begin
				mul_req.a = MUL_A_W'(xmag_q[XMAG_W-1:32]);
				mul_req.b = gmag_q;
			end
			default: begin
				mul_req.a = err_mag;
				mul_req.b = dt_q;
			end
		endcase
	end

	assign div_req.start = (state_q == S_INT);
	assign div_req.num   = {diff_mag, {FRAC_W{1'b0}}};
	assign div_req.den   = dt_q;

	pidc_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (mul_p)
	);

	pidc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;

	logic out_load;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= '0;
			ki_q <= '0;
			kd_q <= '0;
			sp_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PROP_GAIN:  kp_q <= cfg_data;
				REG_INTEG_GAIN: ki_q <= cfg_data;
				REG_DERIV_GAIN: kd_q <= cfg_data;
				REG_TARGET:     sp_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	// sequencer, loop state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			term_q      <= TERM_P;
			esum_q      <= '0;
			lerr_q      <= '0;
			ldrv_q      <= '0;
			err_q       <= '0;
			dt_q        <= '0;
			dneg_q      <= 1'b0;
			sat_q       <= 1'b0;
			xmag_q      <= '0;
			gmag_q      <= '0;
			neg_q       <= 1'b0;
			acc_q       <= '0;
			total_q     <= '0;
			res_drive_q <= '0;
			res_clip_q  <= 1'b0;
			res_bad_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_drive_q <= '0;
			out_clip_q  <= 1'b0;
			out_bad_q   <= 1'b0;
		end else begin
			// drop the result once taken
			if (m_axis_tready && out_valid_q && !out_load)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						err_q   <= err_in;
						dt_q    <= in_dt;
						sat_q   <= 1'b0;
						total_q <= '0;
						if (in_dt == '0) begin
							// zero interval: keep the error, repeat the last drive
							lerr_q      <= err_in;
							res_drive_q <= ldrv_q;
							res_clip_q  <= 1'b0;
							res_bad_q   <= 1'b1;
							state_q     <= S_OUT;
						end else begin
							state_q <= S_INT;
						end
					end
				end
				S_INT: begin
					dneg_q  <= diff[DIFF_W-1];
					state_q <= S_INT_ACC;
				end
				S_INT_ACC: begin
					esum_q  <= sum_sat;
					sat_q   <= sat_q | sum_hi | sum_lo;
					term_q  <= TERM_P;
					state_q <= S_TSET;
				end
				S_TSET: begin
					case (term_q)
						TERM_P: begin
							xmag_q  <= XMAG_W'(err_mag);
							gmag_q  <= abs32(kp_q);
							neg_q   <= kp_q[DATA_W-1] ^ err_q[ERR_W-1];
							state_q <= S_TLO;
						end
						TERM_I: begin
							xmag_q  <= XMAG_W'(esum_mag);
							gmag_q  <= abs32(ki_q);
							neg_q   <= ki_q[DATA_W-1] ^ esum_q[SUM_W-1];
							state_q <= S_TLO;
						end
						default: begin
							// hold until the derivative quotient is ready
							if (div_rsp.done) begin
								xmag_q  <= div_rsp.quo;
								gmag_q  <= abs32(kd_q);
								neg_q   <= kd_q[DATA_W-1] ^ dneg_q;
								state_q <= S_TLO;
							end
						end
					endcase
				end
				S_TLO: begin
					state_q <= S_THI;
				end
				S_THI: begin
					// low partial product plus round-up for a negative term
					acc_q   <= ACC_W'(mul_p) + (neg_q ? ACC_W'(16'hFFFF) : '0);
					state_q <= S_TACC;
				end
				S_TACC: begin
					acc_q   <= acc_q + {mul_p[ACC_W-33:0], 32'd0};
					state_q <= S_TEND;
				end
				S_TEND: begin
					total_q <= total_q + tval;
					sat_q   <= sat_q | tclip;
					case (term_q)
						TERM_P: begin
							term_q  <= TERM_I;
							state_q <= S_TSET;
						end
						TERM_I: begin
							term_q  <= TERM_D;
							state_q <= S_TSET;
						end
						default: begin
							state_q <= S_FIN;
						end
					endcase
				end
				S_FIN: begin
					ldrv_q      <= tot_sat;
					lerr_q      <= err_q;
					res_drive_q <= tot_sat;
					res_clip_q  <= sat_q | tot_hi | tot_lo;
					res_bad_q   <= 1'b0;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					// advance once the output register is free
					if (out_load) begin
						out_valid_q <= 1'b1;
						out_drive_q <= res_drive_q;
						out_clip_q  <= res_clip_q;
						out_bad_q   <= res_bad_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_drive_q;
	assign m_axis_tuser  = {out_bad_q, out_clip_q};

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider restarted while busy");

	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !div_rsp.busy)
		else $error("input taken while the divider still runs");

	a_bad_noclip: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[1]) |-> !m_axis_tuser[0])
		else $error("zero-interval result flagged as clipped");

	a_d_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TLO && term_q == TERM_D) |-> div_rsp.done)
		else $error("derivative term started before the quotient");

endmodule

[tb/sv/tb.sv]
// Self-checking bench for the PID step unit: directed table, then random words under
// several sender/receiver idling patterns and gain settings, checked by a bit-exact
// predictor. Depends on pidc_pkg and pid_controller_step_unit.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pidc_pkg::*;

	// Cycles with no handshake on any channel before the run is declared hung.
	localparam int STALL_LIMIT = 2000;
	// Quiet cycles after the last result, to catch any stray extra word.
	localparam int TAIL_CYCLES = 64;
	localparam int MISS_SHOWN  = 10;

	localparam longint unsigned TERM_CAP = 64'd1 << 60;
	localparam longint SUM_HI    = (longint'(1) <<< 47) - 1;
	localparam longint SUM_LO    = -(longint'(1) <<< 47);
	localparam longint DRIVE_MAX = (longint'(1) <<< 31) - 1;
	localparam longint DRIVE_MIN = -(longint'(1) <<< 31);

	typedef struct packed {
		logic [31:0] drive;
		logic        clipped;
		logic        bad;
	} pid_word_t;

	// One line of the directed table: either a register write (idx, a) or a sample
	// word (a = measured, b = step_time), optionally with its result typed in.
	typedef struct packed {
		bit          is_cfg;
		cfg_reg_t    idx;
		logic [31:0] a;
		logic [31:0] b;
		bit          typed;
		pid_word_t   want;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [63:0]          s_axis_tdata  = '0;  // [31:0] measured, [63:32] step_time
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [DATA_W-1:0]    m_axis_tdata;        // [31:0] drive_value
	logic [1:0]           m_axis_tuser;        // [0] clipped, [1] bad_interval
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	cfg_reg_t             cfg_index     = REG_PROP_GAIN;
	logic [DATA_W-1:0]    cfg_data      = '0;

	// Register mirror and loop state of the predictor.
	int     gain_p, gain_i, gain_d, setpoint;
	longint integ_acc, prev_err, prev_drive;

	pid_word_t drive_due_q[$];   // results owed by the block, oldest first
	int        miss_cnt    = 0;
	int        idle_cycles = 0;
	int        src_idle_pct  = 0;
	int        sink_stall_pct = 0;

	// Typed-in result for the word currently offered, if the table gives one.
	bit        held_typed = 1'b0;
	pid_word_t held_word  = '0;

	pid_controller_step_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic longint unsigned abs_u64(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// (gain * x) >> 16 floored, magnitude capped at 2^60; raise sat on the cap.
	function automatic longint scale_gain(input longint gain, input longint x, inout bit sat);
		longint unsigned g, m, hi, lo, part, mg;
		bit neg;
		g   = abs_u64(gain);
		m   = abs_u64(x);
		neg = (gain < 0) != (x < 0);
		hi  = m >> 16;
		lo  = m & 64'hFFFF;
		if (hi != 0 && g > TERM_CAP / hi) begin
			sat = 1'b1;
			mg  = TERM_CAP;
		end else begin
			part = g * lo;
			// bias the dropped fraction so a negative product floors
			if (neg) part += 64'hFFFF;
			mg = g * hi + (part >> 16);
			if (mg > TERM_CAP) begin
				sat = 1'b1;
				mg  = TERM_CAP;
			end
		end
		return neg ? -longint'(mg) : longint'(mg);
	endfunction

	// Advance the loop state by one sample word and return the result it yields.
	function automatic pid_word_t pid_advance(input logic [31:0] meas_bits,
			input logic [31:0] dt_bits);
		longint meas, err, inc, s, diff, deriv, p, i, d, total;
		longint unsigned dt, m, q;
		bit sat;
		pid_word_t r;
		meas = $signed(meas_bits);
		dt   = dt_bits;
		err  = setpoint - meas;
		sat  = 1'b0;
		r    = '0;
		// zero interval: remember the error, repeat the last drive, flag it
		if (dt == 0) begin
			prev_err = err;
			r.drive  = prev_drive[31:0];
			r.bad    = 1'b1;
			return r;
		end
		m   = abs_u64(err) * dt;
		inc = (err < 0) ? -longint'((m + 64'hFFFF) >> 16) : longint'(m >> 16);
		s   = integ_acc + inc;
		if (s > SUM_HI) begin
			s   = SUM_HI;
			sat = 1'b1;
		end
		if (s < SUM_LO) begin
			s   = SUM_LO;
			sat = 1'b1;
		end
		integ_acc = s;
		diff  = err - prev_err;
		q     = (abs_u64(diff) << 16) / dt;
		deriv = (diff < 0) ? -longint'(q) : longint'(q);
		p     = scale_gain(gain_p, err, sat);
		i     = scale_gain(gain_i, integ_acc, sat);
		d     = scale_gain(gain_d, deriv, sat);
		total = p + i + d;
		if (total > DRIVE_MAX) begin
			total = DRIVE_MAX;
			sat   = 1'b1;
		end
		if (total < DRIVE_MIN) begin
			total = DRIVE_MIN;
			sat   = 1'b1;
		end
		prev_drive = total;
		prev_err   = err;
		r.drive    = total[31:0];
		r.clipped  = sat;
		return r;
	endfunction

	// ---------------------------------------------------------------- monitor

	task automatic note_miss(input string what, input pid_word_t want, input pid_word_t got);
		miss_cnt++;
		if (miss_cnt <= MISS_SHOWN)
			$display("%0t %s: expected drive %h clip %b bad %b, got drive %h clip %b bad %b",
				$realtime, what, want.drive, want.clipped, want.bad,
				got.drive, got.clipped, got.bad);
	endtask

	// Sample every channel at the rising edge. Check results before queueing the
	// word accepted in the same edge: a result never belongs to a word taken with it.
	always @(posedge clk) begin : watch_bus
		pid_word_t got, want;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (m_axis_tvalid && m_axis_tready) begin
				moved = 1'b1;
				got   = '{m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]};
				if (drive_due_q.size() == 0) begin
					note_miss("unexpected word", '0, got);
				end else begin
					want = drive_due_q.pop_front();
					if (got.drive !== want.drive || got.clipped !== want.clipped ||
							got.bad !== want.bad)
						note_miss("mismatch", want, got);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				moved = 1'b1;
				// advance the predictor even where the table types the result in
				want = pid_advance(s_axis_tdata[31:0], s_axis_tdata[63:32]);
				if (held_typed) want = held_word;
				drive_due_q.push_back(want);
			end
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				case (cfg_index)
					REG_PROP_GAIN:  gain_p   = cfg_data;
					REG_INTEG_GAIN: gain_i   = cfg_data;
					REG_DERIV_GAIN: gain_d   = cfg_data;
					REG_TARGET:     setpoint = cfg_data;
					default: ;
				endcase
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
		end
	end

	// Hung-run guard: end the run once nothing has moved for too long.
	initial begin
		wait (idle_cycles >= STALL_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	// Receiver: stall at the configured rate, one decision per cycle.
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// ---------------------------------------------------------------- stimulus

	// Offer one sample word after a random gap and hold it until taken. Now and then
	// a longer gap, so idle input lands at every point of the block's work.
	task automatic send_sample(input logic [31:0] meas, input logic [31:0] dt,
			input bit typed, input pid_word_t want);
		int gap;
		gap = 0;
		if (src_idle_pct != 0 && $urandom_range(7) == 0) gap = $urandom_range(1, 70);
		while (gap > 0 || $urandom_range(99) < src_idle_pct) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			if (gap > 0) gap--;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {dt, meas};
		held_typed = typed;
		held_word  = want;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Drop the input and hold off until every owed result has come back.
	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (drive_due_q.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Gains and setpoints: zero, both extremes, full range, or a modest +-2.0.
	function automatic logic [31:0] pick_q16();
		case ($urandom_range(7))
			0:       return 32'h0000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'h8000_0000;
			3:       return $urandom;
			default: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
		endcase
	endfunction

	// Mostly near the setpoint so the loop stays out of saturation, with full-range
	// values and both extremes mixed in.
	function automatic logic [31:0] pick_measured();
		case ($urandom_range(9))
			0:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			1, 2:    return $urandom;
			default: return setpoint + $urandom_range(0, 32'h3FFFF) - 32'h20000;
		endcase
	endfunction

	function automatic logic [31:0] pick_interval();
		case ($urandom_range(15))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			2:       return 32'h0000_0001;
			3, 4:    return $urandom;
			default: return $urandom_range(1, 32'h20000);
		endcase
	endfunction

	// Directed table. After reset all gains are zero, so the drive stays at zero and
	// only integral saturation can set the clip flag; then the gain extremes push the
	// output into both rails, a zero interval repeats the last drive, and small gains
	// exercise the floor rounding and the shortest interval.
	localparam int N_DIR = 25;
	dir_row_t dir_rows [N_DIR] = '{
		'{1'b0, REG_PROP_GAIN,  32'h0000_0000, 32'h0001_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
		'{1'b0, REG_PROP_GAIN,  32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b1}},
		'{1'b0, REG_PROP_GAIN,  32'h8000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
		'{1'b0, REG_PROP_GAIN,  32'h8000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
		'{1'b0, REG_PROP_GAIN,  32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
		'{1'b1, REG_PROP_GAIN,  32'h7FFF_FFFF, 32'h0,         1'b0, '0},
		'{1'b1, REG_INTEG_GAIN, 32'h8000_0000, 32'h0,         1'b0, '0},
		'{1'b1, REG_DERIV_GAIN, 32'h7FFF_FFFF, 32'h0,         1'b0, '0},
		'{1'b1, REG_TARGET,     32'h7FFF_FFFF, 32'h0,         1'b0, '0},
		'{1'b0, REG_PROP_GAIN,  32'h8000_0000, 32'h0000_0001, 1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b0}},
		'{1'b0, REG_PROP_GAIN,  32'h8000_0000, 32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, 1'b0, 1'b1}},
		'{1'b0, REG_PROP_GAIN,  32'h7FFF_FFFF, 32'h0000_0001, 1'b0, '0},
		'{1'b1, REG_TARGET,     32'h8000_0000, 32'h0,         1'b0, '0},
		'{1'b1, REG_INTEG_GAIN, 32'h0000_0000, 32'h0,         1'b0, '0},
		'{1'b1, REG_DERIV_GAIN, 32'h0000_0000, 32'h0,         1'b0, '0},
		'{1'b0, REG_PROP_GAIN,  32'h7FFF_FFFF, 32'h0001_0000, 1'b1, '{32'h8000_0000, 1'b1, 1'b0}},
		'{1'b1, REG_PROP_GAIN,  32'h0001_0000, 32'h0,         1'b0, '0},
		'{1'b1, REG_TARGET,     32'h0000_0000, 32'h0,         1'b0, '0},
		'{1'b0, REG_PROP_GAIN,  32'h0001_8000, 32'h0001_0000, 1'b0, '0},
		'{1'b1, REG_PROP_GAIN,  32'h0000_8000, 32'h0,         1'b0, '0},
		'{1'b0, REG_PROP_GAIN,  32'h0000_0001, 32'h0001_0000, 1'b0, '0},
		'{1'b1, REG_INTEG_GAIN, 32'hFFFF_0000, 32'h0,         1'b0, '0},
		'{1'b1, REG_DERIV_GAIN, 32'h0001_0000, 32'h0,         1'b0, '0},
		'{1'b0, REG_PROP_GAIN,  32'hFFFF_8000, 32'h0000_0001, 1'b0, '0},
		'{1'b0, REG_PROP_GAIN,  32'h1234_5678, 32'h0000_8000, 1'b0, '0}
	};

	// Idling patterns: none, sender idle, receiver stalling, both lightly.
	localparam int N_MODES = 4;
	int src_pct_of  [N_MODES] = '{0, 64, 0, 9};
	int sink_pct_of [N_MODES] = '{0, 0, 64, 9};

	initial begin
		// predictor starts from the reset state of the block
		gain_p     = 0;
		gain_i     = 0;
		gain_d     = 0;
		setpoint   = 0;
		integ_acc  = 0;
		prev_err   = 0;
		prev_drive = 0;

		// hold reset, then release away from the rising edge
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// walk the directed table with no idling; registers change only when drained
		foreach (dir_rows[k]) begin
			if (dir_rows[k].is_cfg) begin
				wait_drained();
				write_reg(dir_rows[k].idx, dir_rows[k].a);
			end else begin
				send_sample(dir_rows[k].a, dir_rows[k].b, dir_rows[k].typed,
					dir_rows[k].want);
			end
		end

		// random part: two gain settings per idling pattern, 81 words each
		for (int mode = 0; mode < N_MODES; mode++) begin
			src_idle_pct   = src_pct_of[mode];
			sink_stall_pct = sink_pct_of[mode];
			for (int set = 0; set < 2; set++) begin
				wait_drained();
				write_reg(REG_PROP_GAIN,  pick_q16());
				write_reg(REG_INTEG_GAIN, pick_q16());
				write_reg(REG_DERIV_GAIN, pick_q16());
				write_reg(REG_TARGET,     pick_q16());
				repeat (81) begin
					// occasionally starve the block completely before the next word
					if ($urandom_range(39) == 0) wait_drained();
					send_sample(pick_measured(), pick_interval(), 1'b0, '0);
				end
			end
		end

		// drain, then hold off a little longer to catch any stray result
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (drive_due_q.size() != 0) begin
			miss_cnt++;
			$display("%0d results never arrived", drive_due_q.size());
		end
		if (miss_cnt == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
